/* design/assert_macros.svh */
// Assertion macros shared by the deframer RTL.
// Relies on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define EPDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define EPDF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* design/epdf_pkg.sv */
// Shared constants and types for the escaped packet deframer.
// No dependencies.
package epdf_pkg;

  // Packet buffer sizing (one bank per packet, two banks)
  localparam int unsigned BUFFER_BYTES = 64;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int unsigned CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned RAM_AW       = ADDR_W + 1;
  localparam int unsigned RAM_DEPTH    = 2 * BUFFER_BYTES;
  localparam int unsigned PCNT_W       = 6;

  // Command queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Link framing codes
  localparam logic [7:0] MARK_START = 8'hFF;
  localparam logic [7:0] MARK_END   = 8'hFE;
  localparam logic [7:0] MARK_ESC   = 8'hFD;
  // largest escaped byte that does not overflow once MARK_ESC is added
  localparam logic [7:0] ESC_MAX    = 8'hFF - MARK_ESC;
  localparam int unsigned MIN_RECEIVED = 3;

  // Buffer write from the front
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // Verified packet waiting for emission
  typedef struct packed {
    logic              bank;
    logic [PCNT_W-1:0] count;
  } cmd_t;

  // Back end has released a bank
  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

endpackage

/* design/epdf_store.sv */
// Two-bank packet byte buffer: one write port, one registered read port.
// Depends on epdf_pkg.
module epdf_store (
  input  logic                      clk_i,
  input  epdf_pkg::wr_t             wr_i,
  input  logic                      rd_en_i,
  input  logic [epdf_pkg::RAM_AW-1:0] rd_addr_i,
  output logic [7:0]                rd_data_o
);

  logic [7:0] mem_q [epdf_pkg::RAM_DEPTH];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/epdf_front.sv */
// Front end: parses link bytes, stores packet bytes, verifies at the end marker.
// Depends on epdf_pkg.
module epdf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          link_byte_i,
  output epdf_pkg::wr_t       wr_o,
  output logic                push_o,
  output epdf_pkg::cmd_t      push_cmd_o,
  input  epdf_pkg::done_t     done_i,
  output logic [1:0]          busy_o,
  output logic                wr_bank_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IN,
    MODE_ESC
  } mode_e;

  mode_e                       mode_q, mode_d;
  logic [epdf_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]                  sum_q, sum_d;
  logic [7:0]                  b1_q, b1_d;   // last stored byte
  logic [7:0]                  b2_q, b2_d;   // second to last stored byte
  logic                        bank_q, bank_d;
  logic [1:0]                  busy_q, busy_d;

  logic                        accept;
  logic                        keep_en;
  logic [7:0]                  keep_val;
  logic [epdf_pkg::CNT_W-1:0]  cnt_inc;
  logic [7:0]                  cnt_m1;
  logic [7:0]                  chk;
  logic                        good;

  // new bytes wait while the bank to be written is still being emitted
  assign in_stall_o = busy_q[bank_q];
  assign accept     = in_valid_i && !in_stall_o;

  assign cnt_inc = cnt_q + epdf_pkg::CNT_W'(1);
  assign cnt_m1  = 8'(cnt_q) - 8'd1;
  // payload checksum = sum of all stored bytes minus the two trailer bytes
  assign chk     = sum_q - b1_q - b2_q;
  assign good    = (cnt_q >= epdf_pkg::CNT_W'(epdf_pkg::MIN_RECEIVED))
                   && (b1_q == cnt_m1) && (b2_q == chk);

  // parser next state
  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    b1_d     = b1_q;
    b2_d     = b2_q;
    bank_d   = bank_q;
    keep_en  = 1'b0;
    keep_val = link_byte_i;
    push_o   = 1'b0;
    if (accept) begin
      unique case (mode_q)
        MODE_IN: begin
          if (link_byte_i == epdf_pkg::MARK_END) begin
            mode_d = MODE_IDLE;
            if (good) begin
              push_o = 1'b1;
              bank_d = !bank_q;
            end
          end else if (link_byte_i == epdf_pkg::MARK_ESC) begin
            mode_d = MODE_ESC;
          end else begin
            keep_en = 1'b1;
          end
        end
        MODE_ESC: begin
          if (link_byte_i <= epdf_pkg::ESC_MAX) begin
            keep_en  = 1'b1;
            keep_val = link_byte_i + epdf_pkg::MARK_ESC;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
        default: begin
          if (link_byte_i == epdf_pkg::MARK_START) begin
            mode_d = MODE_IN;
            cnt_d  = '0;
            sum_d  = '0;
          end
        end
      endcase
    end
    // store one byte; a full buffer aborts the packet
    if (keep_en) begin
      cnt_d  = cnt_inc;
      sum_d  = sum_q + keep_val;
      b1_d   = keep_val;
      b2_d   = b1_q;
      mode_d = (cnt_inc >= epdf_pkg::CNT_W'(epdf_pkg::BUFFER_BYTES)) ? MODE_IDLE : MODE_IN;
    end
  end

  // bank ownership: set when a packet is queued, cleared when fully emitted
  always_comb begin
    busy_d = busy_q;
    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (push_o) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
      sum_q  <= '0;
      b1_q   <= '0;
      b2_q   <= '0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      b1_q   <= b1_d;
      b2_q   <= b2_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

  assign wr_o.en          = keep_en;
  assign wr_o.addr        = {bank_q, cnt_q[epdf_pkg::ADDR_W-1:0]};
  assign wr_o.data        = keep_val;
  assign push_cmd_o.bank  = bank_q;
  assign push_cmd_o.count = epdf_pkg::PCNT_W'(cnt_q - epdf_pkg::CNT_W'(2));
  assign busy_o           = busy_q;
  assign wr_bank_o        = bank_q;

endmodule

/* design/epdf_queue.sv */
// Short FIFO of verified-packet commands between front and back.
// Depends on epdf_pkg.
module epdf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  epdf_pkg::cmd_t  push_cmd_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            full_o,
  output epdf_pkg::cmd_t  head_o
);

  epdf_pkg::cmd_t              slot_q [epdf_pkg::QDEPTH];
  logic [epdf_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [epdf_pkg::QCNT_W-1:0] fill_q;
  logic                        do_push, do_pop;

  assign valid_o = (fill_q != '0);
  assign full_o  = (fill_q == epdf_pkg::QCNT_W'(epdf_pkg::QDEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign head_o  = slot_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + epdf_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + epdf_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + epdf_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - epdf_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* design/epdf_back.sv */
// Back end: reads a verified packet from the buffer and emits its payload bytes.
// Depends on epdf_pkg.
module epdf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  epdf_pkg::cmd_t              q_head_i,
  output logic                        pop_o,
  output logic                        rd_en_o,
  output logic [epdf_pkg::RAM_AW-1:0] rd_addr_o,
  input  logic [7:0]                  rd_data_i,
  output epdf_pkg::done_t             done_o,
  output logic                        rd_bank_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  payload_byte_o,
  output logic                        last_of_packet_o,
  output logic [epdf_pkg::PCNT_W-1:0] payload_count_o
);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } bk_state_e;

  bk_state_e                   state_q, state_d;
  logic                        bank_q, bank_d;
  logic [epdf_pkg::PCNT_W-1:0] count_q, count_d;
  logic [epdf_pkg::PCNT_W-1:0] idx_q, idx_d;
  logic                        last;
  logic                        out_take;

  assign last     = (epdf_pkg::PCNT_W'(idx_q + epdf_pkg::PCNT_W'(1)) == count_q);
  assign out_take = (state_q == BK_SHOW) && !out_stall_i;

  // emission sequencer: fetch a byte, show it until taken
  always_comb begin
    state_d = state_q;
    bank_d  = bank_q;
    count_d = count_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          bank_d  = q_head_i.bank;
          count_d = q_head_i.count;
          idx_d   = '0;
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: begin
        state_d = BK_SHOW;
      end
      BK_SHOW: begin
        if (!out_stall_i) begin
          if (last) begin
            state_d = BK_IDLE;
          end else begin
            idx_d   = idx_q + epdf_pkg::PCNT_W'(1);
            state_d = BK_FETCH;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      bank_q  <= 1'b0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  assign rd_en_o          = (state_q == BK_FETCH);
  assign rd_addr_o        = {bank_q, epdf_pkg::ADDR_W'(idx_q)};
  assign done_o.valid     = out_take && last;
  assign done_o.bank      = bank_q;
  assign rd_bank_o        = bank_q;
  assign out_valid_o      = (state_q == BK_SHOW);
  assign payload_byte_o   = rd_data_i;
  assign last_of_packet_o = last;
  assign payload_count_o  = count_q;

endmodule

/* design/escaped_packet_deframer_unit.sv */
// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+-----------------------------------------
// in       | in_valid_i   | in_stall_o   | link_byte_i
// out      | out_valid_o  | out_stall_i  | payload_byte_o, last_of_packet_o,
//          |              |              | payload_count_o
//
// Link bytes are taken one per cycle while the buffer bank being filled is free.
// Each payload byte is read from the buffer, then held on the output until it is taken.
// Two buffer banks let a new packet be received while the previous one drains;
// input stalls only when both banks hold packets awaiting emission.
// Reset (rst_ni low, asynchronous) returns the parser to idle and empties the queue.
// Top level of the escaped packet deframer; depends on epdf_pkg and the epdf_* modules.
`include "assert_macros.svh"

module escaped_packet_deframer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  link_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  payload_byte_o,
  output logic                        last_of_packet_o,
  output logic [epdf_pkg::PCNT_W-1:0] payload_count_o
);

  epdf_pkg::wr_t               wr;
  epdf_pkg::cmd_t              push_cmd, head;
  epdf_pkg::done_t             done;
  logic                        push, pop, q_valid, q_full;
  logic [1:0]                  busy;
  logic                        wr_bank, rd_bank;
  logic                        rd_en;
  logic [epdf_pkg::RAM_AW-1:0] rd_addr;
  logic [7:0]                  rd_data;

  // parser and verifier
  epdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .link_byte_i (link_byte_i),
    .wr_o        (wr),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .done_i      (done),
    .busy_o      (busy),
    .wr_bank_o   (wr_bank)
  );

  // packet buffer
  epdf_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // verified packets waiting for the back end
  epdf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .full_o     (q_full),
    .head_o     (head)
  );

  // payload emitter
  epdf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_head_i         (head),
    .pop_o            (pop),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .done_o           (done),
    .rd_bank_o        (rd_bank),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .payload_byte_o   (payload_byte_o),
    .last_of_packet_o (last_of_packet_o),
    .payload_count_o  (payload_count_o)
  );

  // checks
  `EPDF_NEVER(a_queue_overflow, push && q_full, "command queue overflow")
  `EPDF_NEVER(a_write_busy_bank, wr.en && busy[wr_bank], "write into a bank being emitted")
  `EPDF_ASSERT(a_emit_owned_bank, out_valid_o |-> busy[rd_bank], "emitting from a free bank")

endmodule
